// ===== hdl/s2d_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
package s2d_pkg;

  localparam int VALUE_WIDTH = 32;

  // Decimal digits needed for the largest magnitude, 2**(VALUE_WIDTH-1).
  function automatic int dec_digits(input int w);
    longint unsigned v;
    int              n;
    v = 64'(1) << (w - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 0) begin
        n++;
        v = v / 10;
      end
    end
    return n;
  endfunction

  localparam int DIGITS      = dec_digits(VALUE_WIDTH);
  localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  typedef logic [3:0] bcd_t;

  // Operation broadcast to every cell of the digit chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_DABBLE,
    OP_SHIFT
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/s2d_cell.sv =====
// One BCD digit cell: shift-add-3 step for conversion, digit shift for readout.
module s2d_cell (
  input  logic              clk,
  input  s2d_pkg::cell_op_t op,
  input  logic              bit_in,
  input  s2d_pkg::bcd_t     digit_in,
  output logic              bit_out,
  output s2d_pkg::bcd_t     digit
);

  s2d_pkg::bcd_t adj;
  s2d_pkg::bcd_t digit_next;

  // add 3 when the digit would overflow after doubling
  assign adj     = (digit >= 4'd5) ? 4'(digit + 4'd3) : digit;
  assign bit_out = adj[3];

  always_comb begin
    unique case (op)
      s2d_pkg::OP_HOLD:   digit_next = digit;
      s2d_pkg::OP_CLEAR:  digit_next = '0;
      s2d_pkg::OP_DABBLE: digit_next = {adj[2:0], bit_in};
      s2d_pkg::OP_SHIFT:  digit_next = digit_in;
      default:            digit_next = digit;
    endcase
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

// ===== hdl/s2d_chain.sv =====
// Row of BCD cells; cell 0 is the least significant digit.
module s2d_chain (
  input  logic              clk,
  input  s2d_pkg::cell_op_t op,
  input  logic              bit_in,
  output s2d_pkg::bcd_t     top_digit
);

  logic          carry [s2d_pkg::DIGITS+1];
  s2d_pkg::bcd_t dig   [s2d_pkg::DIGITS];

  assign carry[0] = bit_in;

  for (genvar i = 0; i < s2d_pkg::DIGITS; i++) begin : g_cell
    s2d_pkg::bcd_t din;
    if (i == 0) begin : g_first
      assign din = '0;
    end else begin : g_rest
      assign din = dig[i-1];
    end

    s2d_cell u_cell (
      .clk      (clk),
      .op       (op),
      .bit_in   (carry[i]),
      .digit_in (din),
      .bit_out  (carry[i+1]),
      .digit    (dig[i])
    );
  end

  // top carry is zero during conversion: the chain is sized for the largest magnitude
  assign top_digit = carry[s2d_pkg::DIGITS] ? dig[s2d_pkg::DIGITS-1] : dig[s2d_pkg::DIGITS-1];

endmodule

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII converter, top level with control sequencer.
// Steps: accept, VALUE_WIDTH shift-add-3 steps in the BCD chain (one bit per cycle), then
//   shift out leading zero digits, then the sign and digits out (up to 11 characters).
// One number at a time: the input is taken only in idle, once the last character of the
//   previous number is loaded; output stalls hold the readout.
// Reset: rst is synchronous, active high; clears sequencer and output valid.
module signed_int_to_decimal_ascii (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [s2d_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [VALUE_WIDTH-1:0] value, rest zero
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [7:0] char_code
  output logic                           m_axis_tlast   // last_char
);

  localparam int W = s2d_pkg::VALUE_WIDTH;

  s2d_pkg::state_t   state, state_next;
  s2d_pkg::cell_op_t cell_op;
  s2d_pkg::bcd_t     top_digit;

  logic [W-1:0]                    mag;          // magnitude, shifted out MSB first
  logic [W-1:0]                    in_value;
  logic [s2d_pkg::BIT_CNT_W-1:0]   bit_cnt;      // bits still to shift in
  logic [s2d_pkg::DIGIT_CNT_W-1:0] digits_left;  // digit positions not yet shifted out
  logic                            negative_flag;

  logic       in_beat;
  logic       out_free;
  logic       out_load;
  logic [7:0] out_code;
  logic       out_last;

  assign in_value      = s_axis_tdata[W-1:0];
  assign s_axis_tready = (state == s2d_pkg::ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // digit chain: conversion feeds magnitude bits into cell 0
  s2d_chain u_chain (
    .clk       (clk),
    .op        (cell_op),
    .bit_in    (mag[W-1]),
    .top_digit (top_digit)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      s2d_pkg::ST_IDLE: if (in_beat) state_next = s2d_pkg::ST_CONV;
      s2d_pkg::ST_CONV: if (bit_cnt == s2d_pkg::BIT_CNT_W'(1)) state_next = s2d_pkg::ST_SKIP;
      s2d_pkg::ST_SKIP: begin
        // stop at the first nonzero digit, or on the units digit for zero
        if (top_digit != '0 || digits_left == s2d_pkg::DIGIT_CNT_W'(1)) begin
          state_next = negative_flag ? s2d_pkg::ST_SIGN : s2d_pkg::ST_EMIT;
        end
      end
      s2d_pkg::ST_SIGN: if (out_free) state_next = s2d_pkg::ST_EMIT;
      s2d_pkg::ST_EMIT: begin
        if (out_free && digits_left == s2d_pkg::DIGIT_CNT_W'(1)) begin
          state_next = s2d_pkg::ST_IDLE;
        end
      end
      default: state_next = s2d_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cell_op  = s2d_pkg::OP_HOLD;
    out_load = 1'b0;
    out_code = s2d_pkg::ASCII_ZERO | {4'd0, top_digit};
    out_last = (digits_left == s2d_pkg::DIGIT_CNT_W'(1));
    unique case (state)
      s2d_pkg::ST_IDLE: if (in_beat) cell_op = s2d_pkg::OP_CLEAR;
      s2d_pkg::ST_CONV: cell_op = s2d_pkg::OP_DABBLE;
      s2d_pkg::ST_SKIP: begin
        if (top_digit == '0 && digits_left != s2d_pkg::DIGIT_CNT_W'(1)) begin
          cell_op = s2d_pkg::OP_SHIFT;
        end
      end
      s2d_pkg::ST_SIGN: begin
        out_load = out_free;
        out_code = s2d_pkg::ASCII_MINUS;
        out_last = 1'b0;
      end
      s2d_pkg::ST_EMIT: begin
        out_load = out_free;
        if (out_free) cell_op = s2d_pkg::OP_SHIFT;
      end
      default: cell_op = s2d_pkg::OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= s2d_pkg::ST_IDLE;
      m_axis_tvalid <= 1'b0;
      negative_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (in_beat) negative_flag <= in_value[W-1];
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_beat) begin
      // two's complement negate also covers the most negative value
      mag         <= in_value[W-1] ? W'(~in_value + W'(1)) : in_value;
      bit_cnt     <= s2d_pkg::BIT_CNT_W'(W);
      digits_left <= s2d_pkg::DIGIT_CNT_W'(s2d_pkg::DIGITS);
    end else begin
      if (state == s2d_pkg::ST_CONV) begin
        mag     <= {mag[W-2:0], 1'b0};
        bit_cnt <= s2d_pkg::BIT_CNT_W'(bit_cnt - s2d_pkg::BIT_CNT_W'(1));
      end
      if (cell_op == s2d_pkg::OP_SHIFT) begin
        digits_left <= s2d_pkg::DIGIT_CNT_W'(digits_left - s2d_pkg::DIGIT_CNT_W'(1));
      end
    end
    if (out_load) begin
      m_axis_tdata <= out_code;
      m_axis_tlast <= out_last;
    end
  end

`ifndef NO_ASSERTIONS
  // a fresh beat starts a full-width conversion
  assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == s2d_pkg::ST_CONV) && (bit_cnt == s2d_pkg::BIT_CNT_W'(W)))
    else $error("conversion did not start after input beat");

  // the chain holds valid BCD while digits are read out
  assert property (@(posedge clk) disable iff (rst)
    (state == s2d_pkg::ST_EMIT) |-> (top_digit <= 4'd9))
    else $error("non-BCD digit at readout");

  // sign is only emitted for negative inputs
  assert property (@(posedge clk) disable iff (rst)
    (state == s2d_pkg::ST_SIGN) |-> negative_flag)
    else $error("minus sign for non-negative value");

  // every output character is a digit, or a minus that never ends the run
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata == s2d_pkg::ASCII_MINUS && !m_axis_tlast) ||
                       (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39)))
    else $error("bad output character");
`endif

endmodule

// ===== bench/signed_int_to_decimal_ascii_test.sv =====
// Self-checking bench for the signed integer to decimal ASCII converter.
module signed_int_to_decimal_ascii_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected character beat on the master side.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_beat_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [s2d_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;  // [VALUE_WIDTH-1:0] value, rest zero
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;       // [7:0] char_code
  logic                           m_axis_tlast;       // last_char

  // Characters still owed by the block, oldest first.
  char_beat_t expected_chars[$];
  int         failures = 0;

  // Idle odds in percent per cycle, changed per test phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  signed_int_to_decimal_ascii uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decimal text of one value: optional '-', then digits, most significant
  // first. Magnitude is taken unsigned so the most negative value is safe.
  function automatic void predict_text(input logic [s2d_pkg::VALUE_WIDTH-1:0] value);
    logic [s2d_pkg::VALUE_WIDTH-1:0] mag;
    s2d_pkg::bcd_t                   digits[s2d_pkg::DIGITS];
    int                              ndig;
    char_beat_t                      beat;
    begin
      mag = value[s2d_pkg::VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      ndig = 0;
      // do-while: zero still gives one digit
      do begin
        digits[ndig] = s2d_pkg::bcd_t'(mag % 10);
        ndig++;
        mag = mag / 10;
      end while (mag != 0);
      if (value[s2d_pkg::VALUE_WIDTH-1]) begin
        beat.char_code = s2d_pkg::ASCII_MINUS;
        beat.last_char = 1'b0;
        expected_chars.push_back(beat);
      end
      for (int i = ndig - 1; i >= 0; i--) begin
        beat.char_code = s2d_pkg::ASCII_ZERO | {4'h0, digits[i]};
        beat.last_char = (i == 0);
        expected_chars.push_back(beat);
      end
    end
  endfunction

  // Receiver side: random backpressure at the current stall odds.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Monitor: predict on every accepted input beat, then check every accepted
  // output beat against the oldest expectation. Values read here are the ones
  // present before this edge, so both handshakes see the same cycle.
  always @(posedge clk) begin
    char_beat_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        predict_text(s_axis_tdata[s2d_pkg::VALUE_WIDTH-1:0]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected char beat: char_code=%h last_char=%b",
                 m_axis_tdata, m_axis_tlast);
          failures++;
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata !== want.char_code) begin
            $error("char_code: expected %h, got %h", want.char_code, m_axis_tdata);
            failures++;
          end
          if (m_axis_tlast !== want.last_char) begin
            $error("last_char: expected %b, got %b", want.last_char, m_axis_tlast);
            failures++;
          end
        end
      end
    end
  end

  // Offer one value and hold it until the block takes it. Idle cycles come
  // first, with junk on tdata, so tvalid never drops and rises in one step.
  task automatic send_value(input logic [s2d_pkg::VALUE_WIDTH-1:0] value);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= s2d_pkg::IN_TDATA_W'($urandom);
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s2d_pkg::IN_TDATA_W'(value);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Random value with a spread of lengths: full range, short positives,
  // short negatives, and values on either side of a power of ten.
  function automatic logic [s2d_pkg::VALUE_WIDTH-1:0] random_value();
    logic [s2d_pkg::VALUE_WIDTH-1:0] v;
    longint unsigned                 p;
    begin
      case ($urandom_range(3, 0))
        0: v = $urandom;
        1: v = $urandom >> $urandom_range(s2d_pkg::VALUE_WIDTH - 1, 1);
        2: v = -($urandom >> $urandom_range(s2d_pkg::VALUE_WIDTH - 1, 1));
        default: begin
          p = 1;
          repeat ($urandom_range(9, 0)) p = p * 10;
          v = s2d_pkg::VALUE_WIDTH'(p) + s2d_pkg::VALUE_WIDTH'($urandom_range(2, 0)) - 1'b1;
          if ($urandom_range(1, 0)) v = -v;
        end
      endcase
      return v;
    end
  endfunction

  // Extremes, sign edges, digit-count boundaries, bit patterns.
  task automatic test_directed();
    logic [s2d_pkg::VALUE_WIDTH-1:0] picks[$];
    begin
      picks = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                -32'sd7, 32'd12345, 32'd999999999, 32'd1000000000,
                -32'sd999999999, -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE,
                32'd4294967};
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      foreach (picks[i]) send_value(picks[i]);
    end
  endtask

  task automatic run_random(input int count);
    repeat (count) send_value(random_value());
  endtask

  // Back-to-back input, receiver always ready.
  task automatic test_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(110);
  endtask

  task automatic test_sender_idle();
    send_idle_pct  = 63;
    recv_stall_pct = 0;
    run_random(110);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 63;
    run_random(110);
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    run_random(110);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    s_axis_tvalid <= 1'b0;
    recv_stall_pct = 0;
    // let the monitor pick up the last input beat before draining
    @(posedge clk);
    // drain, then give the block time to show any stray beat
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (expected_chars.size() != 0) begin
      $error("char beats missing: %0d still expected", expected_chars.size());
      failures++;
    end
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is far below this.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
